>>> rtl/spot_pkg.sv
// Package for the shape pair overlap test: widths, kind, status and mode codes.
// Has no dependencies; the top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package spot_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
  // Edges, clamped points and centre differences, signed.
  localparam int EDGE_WIDTH  = COORD_WIDTH + 3;
  // Diagonal projections x+y or x-y of edges, signed.
  localparam int DIAG_WIDTH  = COORD_WIDTH + 4;
  // Distance magnitudes and radii, unsigned.
  localparam int MAG_WIDTH   = COORD_WIDTH + 2;
  localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH   = SQ_WIDTH + 1;

  // Cycles from an accepted item to its result strobe.
  localparam int PIPE_DEPTH  = 6;

  typedef enum logic [1:0] {
    KIND_RECT   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_TRI    = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNSUP = 2'd1,
    STAT_BAD   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MODE_NONE = 3'd0,
    MODE_RR   = 3'd1,
    MODE_RC   = 3'd2,
    MODE_CC   = 3'd3,
    MODE_RT   = 3'd4
  } mode_e;

endpackage

`default_nettype wire

>>> rtl/shape_pair_overlap_test.sv
// Shape pair overlap test: six-stage pipeline, one pair per cycle.
// Depends on spot_pkg for widths and codes.
//
// Channel  Dir  Handshake          Payload
// input    in   start_i, busy_o    a_/b_ kind, x, y, w, h, dirs
// result   out  done_o (strobe)    hit_o, status_o
//
// An item is accepted when start_i is high and busy_o is low; busy_o stays low,
// so one item enters every cycle. Its result strobes on done_o once it has
// passed the registered stages: decode, edge, clamp, magnitude, 26x26 multiply,
// then sum and compare of the squared distance. rst_ni clears only the valid
// bits. The receiver cannot stall, so nothing holds the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module shape_pair_overlap_test (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [1:0]                           a_kind_i,
  input  wire logic signed [spot_pkg::COORD_WIDTH-1:0] a_x_i,
  input  wire logic signed [spot_pkg::COORD_WIDTH-1:0] a_y_i,
  input  wire logic [spot_pkg::SIZE_WIDTH-1:0]      a_w_i,
  input  wire logic [spot_pkg::SIZE_WIDTH-1:0]      a_h_i,
  input  wire logic [3:0]                           a_dirs_i,
  input  wire logic [1:0]                           b_kind_i,
  input  wire logic signed [spot_pkg::COORD_WIDTH-1:0] b_x_i,
  input  wire logic signed [spot_pkg::COORD_WIDTH-1:0] b_y_i,
  input  wire logic [spot_pkg::SIZE_WIDTH-1:0]      b_w_i,
  input  wire logic [spot_pkg::SIZE_WIDTH-1:0]      b_h_i,
  input  wire logic [3:0]                           b_dirs_i,
  output logic                                      done_o,
  output logic                                      hit_o,
  output logic [1:0]                                status_o
);

  import spot_pkg::*;

  typedef logic signed [EDGE_WIDTH-1:0] edge_t;
  typedef logic signed [DIAG_WIDTH-1:0] diag_t;
  typedef logic [SIZE_WIDTH-1:0]        size_t;
  typedef logic [MAG_WIDTH-1:0]         mag_t;
  typedef logic [SQ_WIDTH-1:0]          sq_t;

  typedef struct packed {
    mode_e   mode;
    status_e status;
    edge_t   pcx;
    edge_t   pcy;
    size_t   pw;
    size_t   ph;
    edge_t   qcx;
    edge_t   qcy;
    size_t   qw;
    size_t   qh;
    logic    plus;
    logic    side_top;
  } s1_t;

  typedef struct packed {
    mode_e   mode;
    status_e status;
    edge_t   pl;
    edge_t   pr;
    edge_t   pt;
    edge_t   pb;
    edge_t   ql;
    edge_t   qr;
    edge_t   qt;
    edge_t   qb;
    edge_t   pcx;
    edge_t   pcy;
    edge_t   qcx;
    edge_t   qcy;
    size_t   pw;
    size_t   qw;
    logic    plus;
    logic    side_top;
  } s2_t;

  typedef struct packed {
    mode_e   mode;
    status_e status;
    logic    box_meet;
    edge_t   cpx;
    edge_t   cpy;
    edge_t   qcx;
    edge_t   qcy;
    edge_t   ddx;
    edge_t   ddy;
    mag_t    rad;
    diag_t   tv1;
    diag_t   tv2;
    diag_t   rv1;
    diag_t   rv2;
  } s3_t;

  typedef struct packed {
    mode_e   mode;
    status_e status;
    logic    box_meet;
    mag_t    mx;
    mag_t    my;
    mag_t    rad;
    diag_t   tlo;
    diag_t   thi;
    diag_t   rlo;
    diag_t   rhi;
  } s4_t;

  typedef struct packed {
    mode_e   mode;
    status_e status;
    logic    box_meet;
    logic    tri_ok;
    sq_t     sqx;
    sq_t     sqy;
    sq_t     sqr;
  } s5_t;

  logic [PIPE_DEPTH-1:0] vld_d, vld_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  logic    hit_d, hit_q;
  status_e status_d, status_q;

  assign busy_o = 1'b0;

  assign vld_d = {vld_q[PIPE_DEPTH-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: put a rectangle first when there is one, decode the pair,
  // move a triangle corner to the centre of its bounding box.
  always_comb begin
    logic  swap;
    kind_e p_kind, q_kind;
    logic signed [COORD_WIDTH-1:0] p_x, p_y, q_x, q_y;
    size_t p_w, p_h, q_w, q_h;
    logic [3:0] q_dirs;
    logic  is_tri, ul, ur, dl, dr;
    edge_t half;

    swap   = (kind_e'(b_kind_i) == KIND_RECT) && (kind_e'(a_kind_i) != KIND_RECT);
    p_kind = swap ? kind_e'(b_kind_i) : kind_e'(a_kind_i);
    q_kind = swap ? kind_e'(a_kind_i) : kind_e'(b_kind_i);
    p_x    = swap ? b_x_i : a_x_i;
    p_y    = swap ? b_y_i : a_y_i;
    p_w    = swap ? b_w_i : a_w_i;
    p_h    = swap ? b_h_i : a_h_i;
    q_x    = swap ? a_x_i : b_x_i;
    q_y    = swap ? a_y_i : b_y_i;
    q_w    = swap ? a_w_i : b_w_i;
    q_h    = swap ? a_h_i : b_h_i;
    q_dirs = swap ? a_dirs_i : b_dirs_i;

    is_tri = (q_kind == KIND_TRI);
    ul     = q_dirs[0] & q_dirs[2];
    ur     = q_dirs[0] & q_dirs[3];
    dl     = q_dirs[1] & q_dirs[2];
    dr     = q_dirs[1] & q_dirs[3];
    half   = EDGE_WIDTH'($signed({1'b0, q_w >> 1}));

    if (p_kind == KIND_BAD || q_kind == KIND_BAD) begin
      s1_d.mode   = MODE_NONE;
      s1_d.status = STAT_BAD;
    end else if (p_kind == KIND_RECT && q_kind == KIND_RECT) begin
      s1_d.mode   = MODE_RR;
      s1_d.status = STAT_OK;
    end else if (p_kind == KIND_RECT && q_kind == KIND_CIRCLE) begin
      s1_d.mode   = MODE_RC;
      s1_d.status = STAT_OK;
    end else if (p_kind == KIND_RECT && q_kind == KIND_TRI) begin
      s1_d.mode   = MODE_RT;
      s1_d.status = STAT_OK;
    end else if (p_kind == KIND_CIRCLE && q_kind == KIND_CIRCLE) begin
      s1_d.mode   = MODE_CC;
      s1_d.status = STAT_OK;
    end else begin
      s1_d.mode   = MODE_NONE;
      s1_d.status = STAT_UNSUP;
    end

    s1_d.pcx = EDGE_WIDTH'(p_x);
    s1_d.pcy = EDGE_WIDTH'(p_y);
    s1_d.pw  = p_w;
    s1_d.ph  = p_h;
    if (is_tri) begin
      s1_d.qcx = EDGE_WIDTH'(q_x) + ((ul || dl) ? half : -half);
      s1_d.qcy = EDGE_WIDTH'(q_y) + ((ul || ur) ? half : -half);
      s1_d.qh  = q_w;
    end else begin
      s1_d.qcx = EDGE_WIDTH'(q_x);
      s1_d.qcy = EDGE_WIDTH'(q_y);
      s1_d.qh  = q_h;
    end
    s1_d.qw       = q_w;
    s1_d.plus     = ul || dr;
    s1_d.side_top = ul || ur;
  end

  // Stage 2: box edges; the low edge loses floor(size/2), the high one gains the rest.
  always_comb begin
    edge_t pw_lo, pw_hi, ph_lo, ph_hi, qw_lo, qw_hi, qh_lo, qh_hi;

    pw_lo = EDGE_WIDTH'($signed({1'b0, s1_q.pw >> 1}));
    pw_hi = EDGE_WIDTH'($signed({1'b0, s1_q.pw - (s1_q.pw >> 1)}));
    ph_lo = EDGE_WIDTH'($signed({1'b0, s1_q.ph >> 1}));
    ph_hi = EDGE_WIDTH'($signed({1'b0, s1_q.ph - (s1_q.ph >> 1)}));
    qw_lo = EDGE_WIDTH'($signed({1'b0, s1_q.qw >> 1}));
    qw_hi = EDGE_WIDTH'($signed({1'b0, s1_q.qw - (s1_q.qw >> 1)}));
    qh_lo = EDGE_WIDTH'($signed({1'b0, s1_q.qh >> 1}));
    qh_hi = EDGE_WIDTH'($signed({1'b0, s1_q.qh - (s1_q.qh >> 1)}));

    s2_d.mode     = s1_q.mode;
    s2_d.status   = s1_q.status;
    s2_d.pl       = s1_q.pcx - pw_lo;
    s2_d.pr       = s1_q.pcx + pw_hi;
    s2_d.pt       = s1_q.pcy - ph_lo;
    s2_d.pb       = s1_q.pcy + ph_hi;
    s2_d.ql       = s1_q.qcx - qw_lo;
    s2_d.qr       = s1_q.qcx + qw_hi;
    s2_d.qt       = s1_q.qcy - qh_lo;
    s2_d.qb       = s1_q.qcy + qh_hi;
    s2_d.pcx      = s1_q.pcx;
    s2_d.pcy      = s1_q.pcy;
    s2_d.qcx      = s1_q.qcx;
    s2_d.qcy      = s1_q.qcy;
    s2_d.pw       = s1_q.pw;
    s2_d.qw       = s1_q.qw;
    s2_d.plus     = s1_q.plus;
    s2_d.side_top = s1_q.side_top;
  end

  // Stage 3: box overlap, clamp of the circle centre, diagonal projections.
  always_comb begin
    edge_t side;

    side = s2_q.side_top ? s2_q.qt : s2_q.qb;

    s3_d.mode     = s2_q.mode;
    s3_d.status   = s2_q.status;
    s3_d.box_meet = (s2_q.pl < s2_q.qr) && (s2_q.pr > s2_q.ql) &&
                    (s2_q.pt < s2_q.qb) && (s2_q.pb > s2_q.qt);
    s3_d.cpx = (s2_q.qcx < s2_q.pl) ? s2_q.pl :
               ((s2_q.qcx > s2_q.pr) ? s2_q.pr : s2_q.qcx);
    s3_d.cpy = (s2_q.qcy < s2_q.pt) ? s2_q.pt :
               ((s2_q.qcy > s2_q.pb) ? s2_q.pb : s2_q.qcy);
    s3_d.qcx = s2_q.qcx;
    s3_d.qcy = s2_q.qcy;
    s3_d.ddx = s2_q.pcx - s2_q.qcx;
    s3_d.ddy = s2_q.pcy - s2_q.qcy;
    s3_d.rad = (s2_q.mode == MODE_RC) ? MAG_WIDTH'(s2_q.qw)
                                      : MAG_WIDTH'(s2_q.pw) + MAG_WIDTH'(s2_q.qw);
    if (s2_q.plus) begin
      s3_d.tv1 = DIAG_WIDTH'(s2_q.ql) + DIAG_WIDTH'(side);
      s3_d.tv2 = DIAG_WIDTH'(s2_q.qr) + DIAG_WIDTH'(side);
      s3_d.rv1 = DIAG_WIDTH'(s2_q.pl) + DIAG_WIDTH'(s2_q.pt);
      s3_d.rv2 = DIAG_WIDTH'(s2_q.pr) + DIAG_WIDTH'(s2_q.pb);
    end else begin
      s3_d.tv1 = DIAG_WIDTH'(s2_q.ql) - DIAG_WIDTH'(side);
      s3_d.tv2 = DIAG_WIDTH'(s2_q.qr) - DIAG_WIDTH'(side);
      s3_d.rv1 = DIAG_WIDTH'(s2_q.pr) - DIAG_WIDTH'(s2_q.pt);
      s3_d.rv2 = DIAG_WIDTH'(s2_q.pl) - DIAG_WIDTH'(s2_q.pb);
    end
  end

  // Stage 4: distance magnitudes, diagonal intervals.
  always_comb begin
    edge_t dx, dy;
    logic [EDGE_WIDTH-1:0] ax, ay;

    dx = (s3_q.mode == MODE_RC) ? s3_q.cpx - s3_q.qcx : s3_q.ddx;
    dy = (s3_q.mode == MODE_RC) ? s3_q.cpy - s3_q.qcy : s3_q.ddy;
    ax = dx[EDGE_WIDTH-1] ? -dx : dx;
    ay = dy[EDGE_WIDTH-1] ? -dy : dy;

    s4_d.mode     = s3_q.mode;
    s4_d.status   = s3_q.status;
    s4_d.box_meet = s3_q.box_meet;
    s4_d.mx       = ax[MAG_WIDTH-1:0];
    s4_d.my       = ay[MAG_WIDTH-1:0];
    s4_d.rad      = s3_q.rad;
    s4_d.tlo      = (s3_q.tv1 < s3_q.tv2) ? s3_q.tv1 : s3_q.tv2;
    s4_d.thi      = (s3_q.tv1 < s3_q.tv2) ? s3_q.tv2 : s3_q.tv1;
    s4_d.rlo      = (s3_q.rv1 < s3_q.rv2) ? s3_q.rv1 : s3_q.rv2;
    s4_d.rhi      = (s3_q.rv1 < s3_q.rv2) ? s3_q.rv2 : s3_q.rv1;
  end

  // Stage 5: squares, diagonal separation.
  always_comb begin
    s5_d.mode     = s4_q.mode;
    s5_d.status   = s4_q.status;
    s5_d.box_meet = s4_q.box_meet;
    s5_d.tri_ok   = (s4_q.rlo < s4_q.thi) && (s4_q.rhi > s4_q.tlo);
    s5_d.sqx      = SQ_WIDTH'(s4_q.mx) * SQ_WIDTH'(s4_q.mx);
    s5_d.sqy      = SQ_WIDTH'(s4_q.my) * SQ_WIDTH'(s4_q.my);
    s5_d.sqr      = SQ_WIDTH'(s4_q.rad) * SQ_WIDTH'(s4_q.rad);
  end

  // Stage 6: squared distance against squared radius, pick the answer.
  always_comb begin
    logic [SUM_WIDTH-1:0] dsq;
    logic near;

    dsq  = SUM_WIDTH'(s5_q.sqx) + SUM_WIDTH'(s5_q.sqy);
    near = dsq < SUM_WIDTH'(s5_q.sqr);

    case (s5_q.mode)
      MODE_RR:     hit_d = s5_q.box_meet;
      MODE_RC:     hit_d = near;
      MODE_CC:     hit_d = near;
      MODE_RT:     hit_d = s5_q.box_meet & s5_q.tri_ok;
      default:     hit_d = 1'b0;
    endcase
    status_d = s5_q.status;
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    s3_q     <= s3_d;
    s4_q     <= s4_d;
    s5_q     <= s5_d;
    hit_q    <= hit_d;
    status_q <= status_d;
  end

  assign done_o   = vld_q[PIPE_DEPTH-1];
  assign hit_o    = hit_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##PIPE_DEPTH done_o)
    else $error("accepted item did not produce a result on time");

  a_no_ghost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PIPE_DEPTH))
    else $error("result without an accepted item");

  a_hit_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (status_o == STAT_OK))
    else $error("hit reported with a non-ok status");

  a_bad_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (a_kind_i == KIND_BAD || b_kind_i == KIND_BAD))
    |-> ##PIPE_DEPTH (done_o && !hit_o && status_o == STAT_BAD))
    else $error("invalid kind not reported");
`endif

endmodule

`default_nettype wire
